// ===== design/dense_matrix_multiply_macros.svh =====
// Assertion macros shared by the dense matrix multiply modules.
`ifndef DENSE_MATRIX_MULTIPLY_MACROS_SVH
`define DENSE_MATRIX_MULTIPLY_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define DMM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checks that a condition in one cycle is followed by an effect in the next.
`define DMM_ASSERT_NEXT(name, cause, effect, msg) \
	`DMM_ASSERT(name, (cause) |=> (effect), msg)

`endif

// ===== design/dmm_pkg.sv =====
// Package with widths, codes and shared types of the dense matrix multiply.
`timescale 1ns / 1ps
package dmm_pkg;
	localparam int TYPE_W      = 2;
	localparam int IDX_W       = 6;
	localparam int VAL_W       = 32;
	localparam int CFG_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int FRAC_W      = 16;
	localparam int MAX_DIM_DEF = 8;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

	typedef enum logic [TYPE_W-1:0] {
		REQ_LOAD_A  = 2'd0,
		REQ_LOAD_B  = 2'd1,
		REQ_COMPUTE = 2'd2,
		REQ_NONE    = 2'd3
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_ROWS  = 2'd0,
		CFG_NUM_COLS  = 2'd1,
		CFG_INNER_LEN = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_index_t;

	// Tags that travel with one read pair through the multiply-accumulate pipeline.
	typedef struct packed {
		logic             first;
		logic             lastk;
		logic             endp;
		logic [IDX_W-1:0] pos;
	} tag_t;

	// A size of zero acts as one and a size above the maximum acts as the maximum.
	function automatic logic [CFG_W-1:0] eff_dim(logic [CFG_W-1:0] r, logic [CFG_W-1:0] maxd);
		logic [CFG_W-1:0] d;
		d = r;
		if (r == '0) begin
			d = CFG_W'(1);
		end else if (r > maxd) begin
			d = maxd;
		end
		return d;
	endfunction
endpackage

// ===== design/dmm_channels.sv =====
// Request and result channel interfaces of the dense matrix multiply.
`timescale 1ns / 1ps
interface dmm_req_if;
	logic                            valid;
	logic                            ready;
	logic [dmm_pkg::TYPE_W-1:0]      req_type;
	logic [dmm_pkg::IDX_W-1:0]       elem_index;
	logic signed [dmm_pkg::VAL_W-1:0] elem_value;

	modport source(output valid, req_type, elem_index, elem_value, input ready);
	modport sink(input valid, req_type, elem_index, elem_value, output ready);
endinterface

interface dmm_rsp_if;
	logic                            valid;
	logic                            ready;
	logic signed [dmm_pkg::VAL_W-1:0] product_value;
	logic [dmm_pkg::IDX_W-1:0]       product_index;
	logic                            last;

	modport source(output valid, product_value, product_index, last, input ready);
	modport sink(input valid, product_value, product_index, last, output ready);
endinterface

// ===== design/dmm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module dmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/dmm_seq.sv =====
// Sequencer that walks the row, column and inner counters and issues store reads.
`timescale 1ns / 1ps
`include "dense_matrix_multiply_macros.svh"
module dmm_seq #(
	parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   adv,
	input  logic                                   done,
	input  logic [$clog2(MAX_DIM+1)-1:0]           rows,
	input  logic [$clog2(MAX_DIM+1)-1:0]           cols,
	input  logic [$clog2(MAX_DIM+1)-1:0]           inner,
	output logic                                   idle,
	output logic                                   re,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     a_raddr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     b_raddr,
	output logic                                   v_s1,
	output dmm_pkg::tag_t                          tag_s1
);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         i_q, j_q, k_q;
	logic [AW-1:0]            a_base_q, a_addr_q, b_addr_q;
	logic [dmm_pkg::IDX_W-1:0] pos_q;
	logic                     k_last, j_last, i_last;

	assign k_last = (k_q == CNT_W'(inner - DIM_W'(1)));
	assign j_last = (j_q == CNT_W'(cols - DIM_W'(1)));
	assign i_last = (i_q == CNT_W'(rows - DIM_W'(1)));

	assign idle    = (state_q == ST_IDLE);
	assign re      = (state_q == ST_RUN) && adv;
	assign a_raddr = a_addr_q;
	assign b_raddr = b_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
			pos_q    <= '0;
			v_s1     <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= re;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q  <= ST_RUN;
						i_q      <= '0;
						j_q      <= '0;
						k_q      <= '0;
						a_base_q <= '0;
						a_addr_q <= '0;
						b_addr_q <= '0;
						pos_q    <= '0;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (k_last) begin
							k_q   <= '0;
							pos_q <= pos_q + dmm_pkg::IDX_W'(1);
							if (j_last) begin
								j_q      <= '0;
								b_addr_q <= '0;
								i_q      <= i_q + CNT_W'(1);
								a_base_q <= a_base_q + AW'(inner);
								a_addr_q <= a_base_q + AW'(inner);
								if (i_last) begin
									state_q <= ST_DRAIN;
								end
							end else begin
								j_q      <= j_q + CNT_W'(1);
								b_addr_q <= AW'(j_q) + AW'(1);
								a_addr_q <= a_base_q;
							end
						end else begin
							k_q      <= k_q + CNT_W'(1);
							a_addr_q <= a_addr_q + AW'(1);
							b_addr_q <= b_addr_q + AW'(cols);
						end
					end
				end
				ST_DRAIN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			tag_s1.first <= (k_q == '0);
			tag_s1.lastk <= k_last;
			tag_s1.endp  <= k_last && j_last && i_last;
			tag_s1.pos   <= pos_q;
		end
	end

	`DMM_ASSERT(a_addr_in_range, re |-> ({1'b0, a_addr_q} < (AW+1)'(DEPTH)), "A address out of range")
	`DMM_ASSERT(b_addr_in_range, re |-> ({1'b0, b_addr_q} < (AW+1)'(DEPTH)), "B address out of range")
	`DMM_ASSERT(idle_no_flight, (state_q == ST_IDLE) |-> !v_s1, "Read in flight while idle")
	`DMM_ASSERT_NEXT(run_ends_in_drain, re && k_last && j_last && i_last, state_q == ST_DRAIN, "Sequencer missed the drain")
endmodule

// ===== design/dmm_mac.sv =====
// Multiply-accumulate pipeline with rounding, saturation and the result register.
`timescale 1ns / 1ps
`include "dense_matrix_multiply_macros.svh"
module dmm_mac #(
	parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       v_s1,
	input  dmm_pkg::tag_t              tag_s1,
	input  logic [dmm_pkg::VAL_W-1:0]  a_rdata,
	input  logic [dmm_pkg::VAL_W-1:0]  b_rdata,
	output logic                       adv,
	dmm_rsp_if.source                  rsp
);
	localparam int PROD_W = 2 * dmm_pkg::VAL_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int TOP_L  = dmm_pkg::FRAC_W + dmm_pkg::VAL_W - 1;

	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (dmm_pkg::FRAC_W - 1);
	localparam logic [dmm_pkg::VAL_W-1:0] SAT_MAX = {1'b0, {(dmm_pkg::VAL_W-1){1'b1}}};
	localparam logic [dmm_pkg::VAL_W-1:0] SAT_MIN = {1'b1, {(dmm_pkg::VAL_W-1){1'b0}}};

	logic                        v_s2;
	dmm_pkg::tag_t               tag_s2;
	logic signed [PROD_W-1:0]    prod_s2;
	logic signed [ACC_W-1:0]     acc_q;
	logic                        done_s3;
	logic                        end_s3;
	logic [dmm_pkg::IDX_W-1:0]   pos_s3;
	logic                        out_valid_q;
	logic [dmm_pkg::VAL_W-1:0]   out_value_q;
	logic [dmm_pkg::IDX_W-1:0]   out_index_q;
	logic                        out_last_q;
	logic [ACC_W-TOP_L-1:0]      acc_top;
	logic                        fits;
	logic [dmm_pkg::VAL_W-1:0]   sat_value;

	assign adv = !out_valid_q || rsp.ready;

	assign acc_top   = acc_q[ACC_W-1:TOP_L];
	assign fits      = (&acc_top) || !(|acc_top);
	assign sat_value = fits ? acc_q[TOP_L:dmm_pkg::FRAC_W] : (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			done_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s2        <= v_s1;
			done_s3     <= v_s2 && tag_s2.lastk;
			out_valid_q <= done_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2  <= tag_s1;
			prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
			if (v_s2) begin
				acc_q  <= (tag_s2.first ? $signed(ROUND_HALF) : acc_q) + ACC_W'(prod_s2);
				pos_s3 <= tag_s2.pos;
				end_s3 <= tag_s2.endp;
			end
			if (done_s3) begin
				out_value_q <= sat_value;
				out_index_q <= pos_s3;
				out_last_q  <= end_s3;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.product_value = out_value_q;
	assign rsp.product_index = out_index_q;
	assign rsp.last          = out_last_q;

	`DMM_ASSERT_NEXT(acc_held_on_stall, !adv, $stable(acc_q), "Accumulator moved during a stall")
	`DMM_ASSERT_NEXT(sum_completes, adv && v_s2 && tag_s2.lastk, done_s3, "Finished sum was not flagged")
	`DMM_ASSERT_NEXT(result_loaded, adv && done_s3, out_valid_q, "Finished sum did not reach the output")
endmodule

// ===== design/dense_matrix_multiply.sv =====
// Dense matrix multiply top level:
// Loads and computes arrive on the req channel as words; req.ready is high only
// while no product is in progress. A load of A or B at an index inside the store
// writes one store entry in the cycle it is accepted, so loads stream at one word
// per cycle. A compute word starts a walk over rows x cols x inner_len pairs of
// store reads, one pair per cycle from the single read port of each store while
// the output does not stall; that read loop sets the rate. After the read come
// the multiply, accumulate and output registers. Results go out on the rsp channel
// in row-major order, the final one with last set, and req.ready returns after
// that word has been taken. When the receiver holds rsp.ready low, the result
// waits in the output register and the whole read and multiply pipeline stops
// with it; nothing is lost. Reset sets all three sizes to 8 and clears the
// pipeline; store contents are undefined until written. The user must write
// the sizes on the cfg port only while idle; the block does not enforce this.
`timescale 1ns / 1ps
module dense_matrix_multiply #(
	parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dmm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dmm_pkg::CFG_W-1:0]      cfg_data,
	dmm_req_if.sink                        req,
	dmm_rsp_if.source                      rsp
);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int DIM_W = $clog2(MAX_DIM + 1);

	logic [dmm_pkg::CFG_W-1:0] num_rows_q, num_cols_q, inner_len_q;
	logic [DIM_W-1:0]          rows, cols, inner;
	logic                      idle, accept, in_range, start, adv, done, re;
	logic                      a_we, b_we;
	logic [AW-1:0]             a_raddr, b_raddr;
	logic [dmm_pkg::VAL_W-1:0] a_rdata, b_rdata;
	logic                      v_s1;
	dmm_pkg::tag_t             tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= dmm_pkg::CFG_RESET;
			num_cols_q  <= dmm_pkg::CFG_RESET;
			inner_len_q <= dmm_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dmm_pkg::CFG_NUM_ROWS:  num_rows_q  <= cfg_data;
				dmm_pkg::CFG_NUM_COLS:  num_cols_q  <= cfg_data;
				dmm_pkg::CFG_INNER_LEN: inner_len_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign rows  = DIM_W'(dmm_pkg::eff_dim(num_rows_q, dmm_pkg::CFG_W'(MAX_DIM)));
	assign cols  = DIM_W'(dmm_pkg::eff_dim(num_cols_q, dmm_pkg::CFG_W'(MAX_DIM)));
	assign inner = DIM_W'(dmm_pkg::eff_dim(inner_len_q, dmm_pkg::CFG_W'(MAX_DIM)));

	assign req.ready = idle;
	assign accept    = req.valid && idle;
	assign in_range  = ({1'b0, req.elem_index} < (dmm_pkg::IDX_W+1)'(DEPTH));
	assign a_we      = accept && in_range && (req.req_type == dmm_pkg::REQ_LOAD_A);
	assign b_we      = accept && in_range && (req.req_type == dmm_pkg::REQ_LOAD_B);
	assign start     = accept && (req.req_type == dmm_pkg::REQ_COMPUTE);
	assign done      = rsp.valid && rsp.ready && rsp.last;

	dmm_ram #(
		.WIDTH(dmm_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_a_store (
		.clk  (clk),
		.we   (a_we),
		.waddr(req.elem_index[AW-1:0]),
		.wdata(req.elem_value),
		.re   (re),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	dmm_ram #(
		.WIDTH(dmm_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_b_store (
		.clk  (clk),
		.we   (b_we),
		.waddr(req.elem_index[AW-1:0]),
		.wdata(req.elem_value),
		.re   (re),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	dmm_seq #(
		.MAX_DIM(MAX_DIM)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.adv    (adv),
		.done   (done),
		.rows   (rows),
		.cols   (cols),
		.inner  (inner),
		.idle   (idle),
		.re     (re),
		.a_raddr(a_raddr),
		.b_raddr(b_raddr),
		.v_s1   (v_s1),
		.tag_s1 (tag_s1)
	);

	dmm_mac #(
		.MAX_DIM(MAX_DIM)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s1   (v_s1),
		.tag_s1 (tag_s1),
		.a_rdata(a_rdata),
		.b_rdata(b_rdata),
		.adv    (adv),
		.rsp    (rsp)
	);
endmodule

// ===== verif/dense_matrix_multiply_test.sv =====
// Self-checking testbench for dense_matrix_multiply: loads A and B, runs products and checks every result word.
`timescale 1ns / 1ps
module dense_matrix_multiply_test;
	import dmm_pkg::*;

	localparam int MAX_DIM      = 8;
	localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
	localparam int RANDOM_WORDS = 250;
	localparam int DRAIN_CYCLES = 4;
	localparam int END_SETTLE   = 16;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        index;
		logic                    last;
	} product_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_index_t           cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	dmm_req_if req_ch();
	dmm_rsp_if rsp_ch();

	dense_matrix_multiply #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic signed [VAL_W-1:0] a_mem [STORE_DEPTH];
	logic signed [VAL_W-1:0] b_mem [STORE_DEPTH];
	bit                      a_known [STORE_DEPTH];
	bit                      b_known [STORE_DEPTH];
	logic [CFG_W-1:0]        size_rows = CFG_RESET;
	logic [CFG_W-1:0]        size_cols = CFG_RESET;
	logic [CFG_W-1:0]        size_inner = CFG_RESET;
	product_word_t           product_words_due [$];

	bit          calm;
	int unsigned stall_left;
	int unsigned mismatches;
	int unsigned loads_sent;
	int unsigned computes_sent;
	int unsigned ignored_sent;
	int unsigned words_checked;
	int unsigned largest_product;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("[dense_matrix_multiply] ERROR");
		$finish;
	end

	function automatic int unsigned eff_size(input logic [CFG_W-1:0] r);
		int unsigned d;
		d = (r == '0) ? 1 : int'(r);
		return (d > MAX_DIM) ? MAX_DIM : d;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [VAL_W-1:0] operand_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				v = 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
			end
			4, 5, 6: begin
				v = $urandom;
			end
			7: begin
				case ($urandom_range(0, 5))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					3: v = 32'hFFFF_FFFF;
					4: v = 32'h0001_0000;
					default: v = 32'hFFFF_0000;
				endcase
			end
			default: begin
				v = $signed($urandom) >>> $urandom_range(4, 16);
			end
		endcase
		return v;
	endfunction

	function automatic logic [CFG_W-1:0] random_size();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return CFG_W'($urandom_range(9, 15));
		end else if (r < 4) begin
			return CFG_W'($urandom_range(5, 8));
		end
		return CFG_W'($urandom_range(1, 4));
	endfunction

	// Every result is the exact Q32.32 sum, rounded half up to Q16.16 and saturated.
	function automatic void multiply_stores();
		int unsigned             rows;
		int unsigned             cols;
		int unsigned             inner;
		logic signed [63:0]      prod;
		logic signed [71:0]      acc;
		logic signed [71:0]      rounded;
		product_word_t           word;
		rows = eff_size(size_rows);
		cols = eff_size(size_cols);
		inner = eff_size(size_inner);
		for (int i = 0; i < rows; i++) begin
			for (int j = 0; j < cols; j++) begin
				acc = '0;
				for (int k = 0; k < inner; k++) begin
					prod = a_mem[(inner * i + k) % STORE_DEPTH] *
						b_mem[(cols * k + j) % STORE_DEPTH];
					acc = acc + prod;
				end
				rounded = (acc + 72'sd32768) >>> FRAC_W;
				if (rounded > 72'sd2147483647) begin
					word.value = 32'h7FFF_FFFF;
				end else if (rounded < -72'sd2147483648) begin
					word.value = 32'h8000_0000;
				end else begin
					word.value = rounded[VAL_W-1:0];
				end
				word.index = IDX_W'(cols * i + j);
				word.last = (i == rows - 1) && (j == cols - 1);
				product_words_due.push_back(word);
			end
		end
		if (rows * cols > largest_product) begin
			largest_product = rows * cols;
		end
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: mismatch: %s", $realtime, msg);
		end
	endtask

	task automatic send_word(input req_type_t kind, input logic [IDX_W-1:0] index,
			input logic [VAL_W-1:0] value);
		int unsigned gap;
		gap = idle_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.elem_index <= index;
		req_ch.elem_value <= value;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		case (kind)
			REQ_LOAD_A: begin
				a_mem[index] = value;
				a_known[index] = 1'b1;
				loads_sent++;
			end
			REQ_LOAD_B: begin
				b_mem[index] = value;
				b_known[index] = 1'b1;
				loads_sent++;
			end
			REQ_COMPUTE: begin
				multiply_stores();
				computes_sent++;
			end
			default: begin
				ignored_sent++;
			end
		endcase
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (product_words_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t index, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		case (index)
			CFG_NUM_ROWS: size_rows = data;
			CFG_NUM_COLS: size_cols = data;
			CFG_INNER_LEN: size_inner = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
			input logic [CFG_W-1:0] inner);
		wait_drained();
		write_reg(CFG_NUM_ROWS, rows);
		write_reg(CFG_NUM_COLS, cols);
		write_reg(CFG_INNER_LEN, inner);
	endtask

	// Entries that the next product reads are loaded first, so no unwritten entry is ever read.
	task automatic fill_operands();
		int unsigned rows;
		int unsigned cols;
		int unsigned inner;
		rows = eff_size(size_rows);
		cols = eff_size(size_cols);
		inner = eff_size(size_inner);
		for (int n = 0; n < rows * inner; n++) begin
			if (!a_known[n]) begin
				send_word(REQ_LOAD_A, IDX_W'(n), operand_value());
			end
		end
		for (int n = 0; n < inner * cols; n++) begin
			if (!b_known[n]) begin
				send_word(REQ_LOAD_B, IDX_W'(n), operand_value());
			end
		end
	endtask

	task automatic send_compute();
		send_word(REQ_COMPUTE, IDX_W'($urandom), $urandom);
	endtask

	task automatic test_saturation();
		set_sizes(4'd1, 4'd1, 4'd1);
		send_word(REQ_LOAD_A, 6'd0, 32'h8000_0000);
		send_word(REQ_LOAD_B, 6'd0, 32'h8000_0000);
		send_compute();
		send_word(REQ_LOAD_A, 6'd0, 32'h7FFF_FFFF);
		send_compute();
	endtask

	task automatic test_rounding();
		send_word(REQ_LOAD_A, 6'd0, 32'h0000_0001);
		send_word(REQ_LOAD_B, 6'd0, 32'h0000_8000);
		send_compute();
		send_word(REQ_LOAD_A, 6'd0, 32'hFFFF_FFFF);
		send_compute();
		send_word(REQ_LOAD_A, 6'd0, 32'hFFFF_FFFD);
		send_compute();
	endtask

	task automatic test_ignored_fields();
		send_word(REQ_NONE, 6'h3F, 32'hFFFF_FFFF);
		send_word(REQ_NONE, 6'h00, $urandom);
		wait_drained();
		write_reg(CFG_UNUSED, CFG_W'($urandom));
		set_sizes(4'd0, 4'd0, 4'd0);
		send_word(REQ_COMPUTE, 6'h3F, 32'hFFFF_FFFF);
		set_sizes(4'd2, 4'd3, 4'd1);
		fill_operands();
		send_word(REQ_COMPUTE, 6'h00, 32'h0000_0000);
	endtask

	task automatic test_random_products();
		int unsigned start;
		int unsigned r;
		int unsigned span;
		start = loads_sent + computes_sent;
		while (loads_sent + computes_sent - start < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			calm = ($urandom_range(0, 6) == 0);
			if (r < 25) begin
				set_sizes(random_size(), random_size(), random_size());
			end
			if (r < 80) begin
				repeat ($urandom_range(0, 4)) begin
					if ($urandom_range(0, 1) == 1) begin
						span = eff_size(size_inner) * eff_size(size_cols);
						send_word(REQ_LOAD_B, IDX_W'($urandom_range(0, span - 1)),
							operand_value());
					end else begin
						span = eff_size(size_rows) * eff_size(size_inner);
						send_word(REQ_LOAD_A, IDX_W'($urandom_range(0, span - 1)),
							operand_value());
					end
				end
				fill_operands();
				send_compute();
				if ($urandom_range(0, 9) == 0) begin
					wait_drained();
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 2))
						0: send_word(REQ_NONE, IDX_W'($urandom), $urandom);
						1: send_word(REQ_LOAD_A, IDX_W'($urandom), operand_value());
						default: send_word(REQ_LOAD_B, IDX_W'($urandom), operand_value());
					endcase
				end
			end
		end
		calm = 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) begin
				stall_left = idle_gap();
			end
		end
	end

	always @(posedge clk) begin
		product_word_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (product_words_due.size() == 0) begin
				flag_error($sformatf("result word at index %0d with value %h and none expected",
					rsp_ch.product_index, rsp_ch.product_value));
			end else begin
				want = product_words_due.pop_front();
				words_checked++;
				if (rsp_ch.product_value !== want.value) begin
					flag_error($sformatf("value at index %0d: expected %h, got %h",
						want.index, want.value, rsp_ch.product_value));
				end
				if (rsp_ch.product_index !== want.index) begin
					flag_error($sformatf("index: expected %0d, got %0d",
						want.index, rsp_ch.product_index));
				end
				if (rsp_ch.last !== want.last) begin
					flag_error($sformatf("last at index %0d: expected %b, got %b",
						want.index, want.last, rsp_ch.last));
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_NUM_ROWS;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_NONE;
		req_ch.elem_index = '0;
		req_ch.elem_value = '0;
		rsp_ch.ready = 1'b0;
		calm = 1'b0;
		stall_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_saturation();
		test_rounding();
		test_ignored_fields();
		test_random_products();

		wait_drained();
		repeat (END_SETTLE) @(negedge clk);
		$display("Sent %0d loads, %0d products and %0d ignored words; checked %0d result words.",
			loads_sent, computes_sent, ignored_sent, words_checked);
		$display("Largest product had %0d elements; %0d mismatches found.",
			largest_product, mismatches);
		if (mismatches == 0) begin
			$display("[dense_matrix_multiply] OK");
		end else begin
			$display("[dense_matrix_multiply] ERROR");
		end
		$finish;
	end
endmodule
